// File: sv/bgi_pkg.sv
// Shared types and constants for the bilinear grid interpolator.
// No dependencies; imported by every module of the block.
package bgi_pkg;

    localparam int GRID_SIZE_DEF = 128;

    localparam int COORD_W    = 23;
    localparam int SCALE_W    = 24;
    localparam int VAL_W      = 24;
    localparam int SPROD_W    = COORD_W + SCALE_W;
    localparam int GRID_SHIFT = 12;
    localparam int FRAC_W     = 16;
    localparam int HI_W       = 20;
    localparam int GR_W       = HI_W + FRAC_W;
    localparam int WF_W       = FRAC_W + 1;
    localparam int WT_W       = 33;
    localparam int ACC_W      = WT_W + 1 + VAL_W;
    localparam int RES_LSB    = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    localparam logic [GR_W-1:0]         GR_HALF     = GR_W'(32'h0000_8000);
    localparam logic [WF_W-1:0]         WT_ONE      = WF_W'(32'h0001_0000);
    localparam logic signed [ACC_W-1:0] ACC_HALF    = ACC_W'(64'h0000_0000_8000_0000);
    localparam logic [COORD_W-1:0]      LIMIT_RESET = 23'h7F_FFFF;
    localparam logic [SCALE_W-1:0]      SCALE_RESET = 24'h01_0000;

    localparam logic [CFG_IDX_W-1:0] REG_COORD_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SCALE  = 1'b1;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ABOVE = 2'd1;
    localparam logic [1:0] ST_NEG   = 2'd2;

    typedef struct packed {
        logic              kind;
        logic [6:0]        row_index;
        logic [6:0]        col_index;
        logic signed [23:0] entry_value;
        logic signed [23:0] x_coord;
        logic signed [23:0] y_coord;
    } in_word_t;

    typedef struct packed {
        logic signed [23:0] interp_value;
        logic [1:0]         status;
    } out_word_t;

    typedef struct packed {
        logic       accept;
        logic       short_result;
        logic       load_query;
        logic       scale_x;
        logic       scale_y;
        logic       loc_x;
        logic       loc_y;
        logic       clear;
        logic       read;
        logic [1:0] rd_sel;
        logic       mul;
        logic       accum;
        logic       load_ok;
    } bgi_cmd_t;

    typedef struct packed {
        logic       is_query;
        logic [1:0] err_code;
    } bgi_stat_t;

endpackage

// File: sv/bgi_datapath.sv
// Datapath: configuration registers, grid memory, scaling multiplier,
// index/weight logic and the multiply-accumulate. Depends on bgi_pkg.
module bgi_datapath
    import bgi_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  in_word_t              item,
    input  bgi_cmd_t              cmd,
    output bgi_stat_t             stat,
    output out_word_t             result
);

    localparam int IDX_W  = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int WFP_W  = 2 * WF_W;
    localparam logic [HI_W-1:0] IDX_MAX = HI_W'(GRID_SIZE - 1);

    logic [COORD_W-1:0] coord_limit_reg;
    logic [SCALE_W-1:0] cell_scale_reg;

    logic [VAL_W-1:0] mem [DEPTH];
    logic signed [VAL_W-1:0] q_reg;

    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic [SPROD_W-1:0] sprod_reg;

    logic [IDX_W-1:0]  xl_reg, xh_reg, yl_reg, yh_reg;
    logic [FRAC_W-1:0] tx_reg, ty_reg;

    logic [WT_W-1:0]         w_reg;
    logic signed [ACC_W-1:0] mprod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    out_word_t               result_reg;

    logic above, neg;
    logic [1:0] err_code;
    logic wr_ok;
    logic [IDX_W-1:0] wr_row, wr_col;
    logic [COORD_W-1:0] mul_a;
    logic [GR_W-1:0] gr;
    logic [HI_W-1:0] hi_full, lo_full;
    logic [IDX_W-1:0] loc_hi, loc_lo;
    logic [IDX_W-1:0] rd_row, rd_col;
    logic [WF_W-1:0] wx, wy;
    logic [WFP_W-1:0] w_full;
    logic signed [ACC_W-1:0] rnd;

    // input checks: above-limit wins over negative
    assign above = (!item.x_coord[23] && (item.x_coord[22:0] > coord_limit_reg))
                || (!item.y_coord[23] && (item.y_coord[22:0] > coord_limit_reg));
    assign neg   = item.x_coord[23] || item.y_coord[23];
    assign err_code = above ? ST_ABOVE : (neg ? ST_NEG : ST_OK);

    assign stat.is_query = (item.kind == KIND_QUERY);
    assign stat.err_code = err_code;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coord_limit_reg <= LIMIT_RESET;
            cell_scale_reg  <= SCALE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_COORD_LIMIT: coord_limit_reg <= cfg_data[COORD_W-1:0];
                REG_CELL_SCALE:  cell_scale_reg  <= cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // grid store
    assign wr_row = IDX_W'(item.row_index);
    assign wr_col = IDX_W'(item.col_index);
    assign wr_ok  = cmd.accept && (item.kind == KIND_WRITE)
                 && (32'(item.row_index) < 32'(GRID_SIZE))
                 && (32'(item.col_index) < 32'(GRID_SIZE));

    assign rd_row = cmd.rd_sel[0] ? xh_reg : xl_reg;
    assign rd_col = cmd.rd_sel[1] ? yh_reg : yl_reg;

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[{wr_row, wr_col}] <= item.entry_value;
        end
        if (cmd.read)
        begin
            q_reg <= mem[{rd_row, rd_col}];
        end
    end

    // scale to grid units, then index and weight
    assign mul_a   = cmd.scale_x ? x_reg : y_reg;
    assign gr      = {1'b0, sprod_reg[SPROD_W-1:GRID_SHIFT]} + GR_HALF;
    assign hi_full = gr[GR_W-1:FRAC_W];
    assign lo_full = (hi_full == '0) ? '0 : hi_full - HI_W'(1);
    assign loc_hi  = (hi_full > IDX_MAX) ? IDX_MAX[IDX_W-1:0] : hi_full[IDX_W-1:0];
    assign loc_lo  = (lo_full > IDX_MAX) ? IDX_MAX[IDX_W-1:0] : lo_full[IDX_W-1:0];

    // corner weight: upper index takes t, lower takes 1 - t
    assign wx     = cmd.rd_sel[0] ? {1'b0, tx_reg} : WT_ONE - {1'b0, tx_reg};
    assign wy     = cmd.rd_sel[1] ? {1'b0, ty_reg} : WT_ONE - {1'b0, ty_reg};
    assign w_full = WFP_W'(wx) * WFP_W'(wy);

    assign rnd = acc_reg + ACC_HALF;

    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            x_reg <= item.x_coord[COORD_W-1:0];
            y_reg <= item.y_coord[COORD_W-1:0];
        end
        if (cmd.scale_x || cmd.scale_y)
        begin
            sprod_reg <= SPROD_W'(mul_a) * SPROD_W'(cell_scale_reg);
        end
        if (cmd.loc_x)
        begin
            xl_reg <= loc_lo;
            xh_reg <= loc_hi;
            tx_reg <= gr[FRAC_W-1:0];
        end
        if (cmd.loc_y)
        begin
            yl_reg <= loc_lo;
            yh_reg <= loc_hi;
            ty_reg <= gr[FRAC_W-1:0];
        end
        if (cmd.read)
        begin
            w_reg <= w_full[WT_W-1:0];
        end
        if (cmd.mul)
        begin
            mprod_reg <= ACC_W'($signed({1'b0, w_reg})) * ACC_W'(q_reg);
        end
        if (cmd.clear)
        begin
            acc_reg <= '0;
        end
        else if (cmd.accum)
        begin
            acc_reg <= acc_reg + mprod_reg;
        end
        if (cmd.short_result)
        begin
            result_reg.interp_value <= '0;
            result_reg.status       <= stat.is_query ? err_code : ST_OK;
        end
        else if (cmd.load_ok)
        begin
            result_reg.interp_value <= rnd[RES_LSB+VAL_W-1:RES_LSB];
            result_reg.status       <= ST_OK;
        end
    end

    assign result = result_reg;

endmodule

// File: sv/bgi_ctrl.sv
// Controller state machine: sequences scaling, four grid reads and the
// accumulate for a valid query; writes and rejected queries are answered from idle. Depends on bgi_pkg.
module bgi_ctrl
    import bgi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  bgi_stat_t stat,
    output bgi_cmd_t  cmd,
    output logic      busy,
    output logic      done
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_SCX  = 11'b000_0000_0010,
        S_SCY  = 11'b000_0000_0100,
        S_LOCY = 11'b000_0000_1000,
        S_RD0  = 11'b000_0001_0000,
        S_RD1  = 11'b000_0010_0000,
        S_RD2  = 11'b000_0100_0000,
        S_RD3  = 11'b000_1000_0000,
        S_DR1  = 11'b001_0000_0000,
        S_DR2  = 11'b010_0000_0000,
        S_FIN  = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;
    logic   accept, run_query;

    assign accept    = start && (state_reg == S_IDLE);
    assign run_query = stat.is_query && (stat.err_code == ST_OK);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cmd.accept = accept;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.short_result = !run_query;
                    cmd.load_query   = run_query;
                    if (run_query)
                    begin
                        state_next = S_SCX;
                    end
                end
            end
            S_SCX:
            begin
                cmd.scale_x = 1'b1;
                state_next  = S_SCY;
            end
            S_SCY:
            begin
                cmd.scale_y = 1'b1;
                cmd.loc_x   = 1'b1;
                state_next  = S_LOCY;
            end
            S_LOCY:
            begin
                cmd.loc_y  = 1'b1;
                cmd.clear  = 1'b1;
                state_next = S_RD0;
            end
            S_RD0:
            begin
                cmd.read   = 1'b1;
                cmd.rd_sel = 2'd0;
                state_next = S_RD1;
            end
            S_RD1:
            begin
                cmd.read   = 1'b1;
                cmd.rd_sel = 2'd1;
                cmd.mul    = 1'b1;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                cmd.read   = 1'b1;
                cmd.rd_sel = 2'd2;
                cmd.mul    = 1'b1;
                cmd.accum  = 1'b1;
                state_next = S_RD3;
            end
            S_RD3:
            begin
                cmd.read   = 1'b1;
                cmd.rd_sel = 2'd3;
                cmd.mul    = 1'b1;
                cmd.accum  = 1'b1;
                state_next = S_DR1;
            end
            S_DR1:
            begin
                cmd.mul    = 1'b1;
                cmd.accum  = 1'b1;
                state_next = S_DR2;
            end
            S_DR2:
            begin
                cmd.accum  = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.load_ok = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign done_next = cmd.short_result || cmd.load_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    a_short_done: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !run_query) |=> (done_reg && state_reg == S_IDLE))
        else $error("write or rejected query gave no word");

    a_query_run: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && run_query) |=> (!done_reg && state_reg == S_SCX))
        else $error("valid query did not start the sequence");

    a_fin_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |=> done_reg)
        else $error("finished query gave no word");

    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == S_FIN
                      || ($past(accept) && !$past(run_query))))
        else $error("word strobed without a source");

endmodule

// File: sv/bilinear_grid_interpolator.sv
// Bilinear grid interpolator top level: controller plus datapath.
// Write words and rejected queries: result strobed 1 cycle after start; 1 item/cycle.
// Valid queries: result strobed after SCX, SCY (scaling multiplier), LOCY, RD0-RD3
// (four single-port grid memory reads), DR1, DR2 and FIN; next start taken with it.
// Reset clears control and config; grid entries are undefined until written.
module bilinear_grid_interpolator
    import bgi_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  start,
    input  in_word_t              item,
    output logic                  busy,
    output logic                  done,
    output out_word_t             result
);

    bgi_cmd_t  cmd;
    bgi_stat_t stat;

    bgi_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    bgi_datapath #(
        .GRID_SIZE (GRID_SIZE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result)
    );

endmodule

// File: tb/bilinear_grid_interpolator_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for bilinear_grid_interpolator: grid writes, queries and config.
// Depends on bgi_pkg and the block's top level; a built-in predictor supplies each result word.
module bilinear_grid_interpolator_tb
    import bgi_pkg::*;
();

    localparam int GRID         = GRID_SIZE_DEF;
    localparam int MAX_COORD    = 8388607;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS  = 200;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  start     = 1'b0;
    in_word_t              item      = '0;
    logic                  busy;
    logic                  done;
    out_word_t             result;

    bilinear_grid_interpolator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .done      (done),
        .result    (result)
    );

    logic signed [VAL_W-1:0] grid_model [GRID*GRID];
    bit                      written_map [GRID*GRID];
    logic [COORD_W-1:0]      limit_model = LIMIT_RESET;
    logic [SCALE_W-1:0]      scale_model = SCALE_RESET;
    out_word_t               pending_words [$];

    int mismatches = 0;
    int items_sent = 0;
    int burst_left = 0;
    int n_writes   = 0;
    int n_ok       = 0;
    int n_above    = 0;
    int n_neg      = 0;
    int n_phases   = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("timeout with %0d words outstanding", pending_words.size());
        $display("bilinear_grid_interpolator test failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // ---------------- predictor ----------------

    function automatic void locate_axis(input logic [COORD_W-1:0] coord, output int lo,
                                        output int hi, output longint wt);
        logic [63:0] g;
        logic [63:0] gr;
        logic [63:0] h;
        g  = (64'(coord) * 64'(scale_model)) >> GRID_SHIFT;
        gr = g + 64'h8000;
        h  = gr >> FRAC_W;
        if (h == 64'd0)
            lo = 0;
        else if (h - 64'd1 > 64'(GRID - 1))
            lo = GRID - 1;
        else
            lo = int'(h - 64'd1);
        hi = (h > 64'(GRID - 1)) ? GRID - 1 : int'(h);
        wt = longint'(gr[15:0]);
    endfunction

    function automatic logic [1:0] query_status(input logic signed [23:0] x,
                                                input logic signed [23:0] y);
        int xs;
        int ys;
        int lim;
        xs  = int'(x);
        ys  = int'(y);
        lim = int'(limit_model);
        if (xs > lim || ys > lim)
            return ST_ABOVE;
        if (xs < 0 || ys < 0)
            return ST_NEG;
        return ST_OK;
    endfunction

    function automatic longint sample_at(input int r, input int c);
        return longint'(grid_model[r*GRID + c]);
    endfunction

    function automatic out_word_t blend_predict(input logic signed [23:0] x,
                                                input logic signed [23:0] y);
        int        xl, xh, yl, yh;
        longint    t, u, t1, u1, acc;
        out_word_t r;
        r        = '0;
        r.status = query_status(x, y);
        if (r.status != ST_OK)
            return r;
        locate_axis(x[22:0], xl, xh, t);
        locate_axis(y[22:0], yl, yh, u);
        t1  = 65536 - t;
        u1  = 65536 - u;
        acc = t1 * u1 * sample_at(xl, yl) + t * u1 * sample_at(xh, yl)
            + t1 * u * sample_at(xl, yh) + t * u * sample_at(xh, yh);
        acc = (acc + 64'sd2147483648) >>> RES_LSB;
        r.interp_value = acc[23:0];
        return r;
    endfunction

    function automatic out_word_t apply_word(input in_word_t w);
        out_word_t r;
        int        idx;
        if (w.kind == KIND_WRITE)
        begin
            idx              = int'(w.row_index) * GRID + int'(w.col_index);
            grid_model[idx]  = w.entry_value;
            written_map[idx] = 1'b1;
            n_writes++;
            return '0;
        end
        r = blend_predict(w.x_coord, w.y_coord);
        case (r.status)
            ST_OK:    n_ok++;
            ST_ABOVE: n_above++;
            default:  n_neg++;
        endcase
        return r;
    endfunction

    // ---------------- result check ----------------

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && done)
        begin
            if (pending_words.size() == 0)
                report_mismatch($sformatf("unexpected result word %h", result));
            else
            begin
                want = pending_words.pop_front();
                if (result.interp_value !== want.interp_value)
                    report_mismatch($sformatf("interp_value %h, want %h",
                                              result.interp_value, want.interp_value));
                if (result.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              result.status, want.status));
            end
        end
    end

    // ---------------- stimulus helpers ----------------

    task automatic send_word(input in_word_t w);
        if (!start)
            start <= 1'b1;
        item <= w;
        do
            @(posedge clk);
        while (busy);
        pending_words.push_back(apply_word(w));
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
        end
    endtask

    task automatic drain();
        if (start)
            start <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input int limit, input int scale);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= REG_COORD_LIMIT;
        cfg_data  <= {1'($urandom), limit[22:0]};
        @(posedge clk);
        cfg_index <= REG_CELL_SCALE;
        cfg_data  <= scale[23:0];
        @(posedge clk);
        cfg_write   <= 1'b0;
        limit_model = limit[22:0];
        scale_model = scale[23:0];
        repeat (2) @(posedge clk);
    endtask

    function automatic logic signed [23:0] random_value();
        case ($urandom_range(7))
            0:       return 24'sh800000;
            1:       return 24'sh7FFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic in_word_t random_word();
        in_word_t w;
        w.kind        = 1'($urandom);
        w.row_index   = 7'($urandom);
        w.col_index   = 7'($urandom);
        w.entry_value = random_value();
        w.x_coord     = 24'($urandom);
        w.y_coord     = 24'($urandom);
        return w;
    endfunction

    function automatic int coord_in_limit();
        case ($urandom_range(9))
            0:       return 0;
            1:       return int'(limit_model);
            default: return $urandom_range(0, int'(limit_model));
        endcase
    endfunction

    task automatic write_entry(input int r, input int c, input logic signed [23:0] v);
        in_word_t w;
        w             = random_word();
        w.kind        = KIND_WRITE;
        w.row_index   = r[6:0];
        w.col_index   = c[6:0];
        w.entry_value = v;
        send_word(w);
    endtask

    task automatic fill_cell(input int r, input int c);
        if (!written_map[r*GRID + c])
            write_entry(r, c, random_value());
    endtask

    // every corner a valid query reads is written first
    task automatic issue_query(input int x, input int y);
        in_word_t w;
        int       xl, xh, yl, yh;
        longint   t, u;
        w         = random_word();
        w.kind    = KIND_QUERY;
        w.x_coord = 24'(x);
        w.y_coord = 24'(y);
        if (query_status(w.x_coord, w.y_coord) == ST_OK)
        begin
            locate_axis(w.x_coord[22:0], xl, xh, t);
            locate_axis(w.y_coord[22:0], yl, yh, u);
            fill_cell(xl, yl);
            fill_cell(xh, yl);
            fill_cell(xl, yh);
            fill_cell(xh, yh);
        end
        send_word(w);
    endtask

    task automatic run_random_phase(input int limit, input int scale);
        int       stop_at;
        int       pick;
        int       x, y, tmp;
        in_word_t w;
        set_config(limit, scale);
        n_phases++;
        stop_at = items_sent + PHASE_ITEMS;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 45 || (pick < 82 && pick >= 70 && limit_model == LIMIT_RESET))
                issue_query(coord_in_limit(), coord_in_limit());
            else if (pick < 70)
                write_entry($urandom_range(GRID - 1), $urandom_range(GRID - 1), random_value());
            else if (pick < 92)
            begin
                if (pick < 82)
                begin
                    x = $urandom_range(int'(limit_model) + 1, MAX_COORD);
                    y = int'($signed(24'($urandom)));
                end
                else
                begin
                    x = -int'($urandom_range(1, 8388608));
                    y = $urandom_range(1) ? coord_in_limit() : -int'($urandom_range(1, 8388608));
                end
                if ($urandom_range(1))
                begin
                    tmp = x;
                    x   = y;
                    y   = tmp;
                end
                issue_query(x, y);
            end
            else
            begin
                w = random_word();
                if (w.kind == KIND_QUERY)
                    issue_query(int'(w.x_coord), int'(w.y_coord));
                else
                    send_word(w);
            end
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_default_corners();
        write_entry(0, 0, 24'sh7FFFFF);
        write_entry(GRID - 1, GRID - 1, 24'sh800000);
        write_entry(0, GRID - 1, 24'sh000000);
        write_entry(GRID - 1, 0, 24'shFFFFFF);
        issue_query(0, 0);
        issue_query(MAX_COORD, MAX_COORD);
        issue_query(0, MAX_COORD);
        issue_query(MAX_COORD, 0);
    endtask

    task automatic test_rejects();
        set_config(128 << 12, 65536);
        issue_query((128 << 12) + 1, 0);
        issue_query(0, MAX_COORD);
        issue_query(-1, 0);
        issue_query(0, -8388608);
        issue_query(-1, MAX_COORD);
        issue_query(MAX_COORD, -1);
    endtask

    // rounding at a cell centre, just below it, mid grid, at the far edge and at an interior point
    task automatic test_cell_edges();
        issue_query(2047, 2047);
        issue_query(2048, 2048);
        issue_query(64 << 12, 64 << 12);
        issue_query(128 << 12, 128 << 12);
        issue_query((10 << 12) + 1234, (77 << 12) + 3000);
    endtask

    task automatic test_random_settings();
        run_random_phase(128 << 12, 65536);
        run_random_phase(MAX_COORD, 4096);
        run_random_phase(0, 32'h00FF_FFFF);
        run_random_phase($urandom_range(1, MAX_COORD), 0);
        run_random_phase(4096, 32'h0080_0000);
        run_random_phase(MAX_COORD, 32'h00FF_FFFF);
        run_random_phase($urandom_range(1, MAX_COORD), $urandom_range(1, 32'h00FF_FFFF));
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_corners();
        test_rejects();
        test_cell_edges();
        test_random_settings();

        if (start)
            start <= 1'b0;
        for (int i = 0; i < 1000 && pending_words.size() != 0; i++)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        while (pending_words.size() != 0)
        begin
            void'(pending_words.pop_front());
            report_mismatch("expected word never arrived");
        end

        $display("%0d words sent over %0d random config phases: %0d writes, %0d queries",
                 items_sent, n_phases, n_writes, n_ok + n_above + n_neg);
        $display("queries blended %0d, above limit %0d, negative %0d; %0d mismatches",
                 n_ok, n_above, n_neg, mismatches);
        if (mismatches == 0)
            $display("bilinear_grid_interpolator test passed");
        else
            $display("bilinear_grid_interpolator test failed");
        $finish;
    end

endmodule
